// ===== hw/rtl/saa_pkg.sv =====
// shared constants, types and helper functions for the solar altitude/azimuth pipeline
`default_nettype none

package saa_pkg;

    // angle resolution of the cordic units, 2^ANGLE_BITS units per turn
    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int ZW       = ANGLE_BITS + 2;   // cordic angle accumulator
    localparam int RW       = 34;               // rotation x/y, q30
    localparam int MW       = 36;               // products and sun vector, q30
    localparam int VW       = 37;               // vectoring x/y, q30 plus growth
    localparam int SQW      = 62;               // square root remainder/root
    localparam int SQ_STEPS = 31;               // one root bit per step

    localparam logic signed [RW-1:0] GAIN_INV = RW'(652032874);

    // atan(2^-i) in 2^32 units per turn
    localparam logic [31:0] ATAN_TURN32 [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [1:0] {
        CFG_DECL_SINE   = 2'd0,
        CFG_DECL_COSINE = 2'd1,
        CFG_LAT_SINE    = 2'd2,
        CFG_LAT_COSINE  = 2'd3
    } t_cfg_idx;

    // rounded outputs and azimuth qualifier that travel beside the angle units
    typedef struct packed {
        logic signed [15:0] east;
        logic signed [15:0] north;
        logic signed [15:0] up;
        logic               az_ok;
    } t_side;

    // arctangent table entry at cordic resolution, half rounds up
    function automatic logic signed [ZW-1:0] atan_ent(input int i);
        logic [32:0] t;
        t = {1'b0, ATAN_TURN32[i % 32]};
        if (ANGLE_BITS < 32) begin
            t = (t + (33'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
        end
        return ZW'(t);
    endfunction

    // hour angle (65536 per turn) to cordic units
    function automatic logic signed [ZW-1:0] ang_in(input logic signed [15:0] h);
        logic signed [63:0] v;
        v = 64'(h) <<< 16;
        if (ANGLE_BITS < 32) begin
            v = (v + (64'sd1 <<< (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
        end
        return v[ZW-1:0];
    endfunction

    // cordic units to 65536 per turn
    function automatic logic signed [63:0] ang_out(input logic signed [ZW-1:0] z);
        logic signed [63:0] v;
        v = 64'(z);
        if (ANGLE_BITS > 16) begin
            v = (v + (64'sd1 <<< (ANGLE_BITS - 17))) >>> (ANGLE_BITS - 16);
        end else if (ANGLE_BITS < 16) begin
            v = v <<< (16 - ANGLE_BITS);
        end
        return v;
    endfunction

    // round away 15 fraction bits, half up
    function automatic logic signed [63:0] rnd15(input logic signed [63:0] v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/solar_altitude_azimuth_top.sv =====
// top level of the solar altitude/azimuth pipeline
`default_nettype none

// Solar direction unit. Each request carries an hour angle (65536 units per
// turn); each result carries the east, north and up components of the unit
// sun vector in Q1.15, the altitude (asin of the up component, clipped) and
// the azimuth from north toward east, which reads 0 when the sun is below the
// horizon. Latitude and declination come from four Q1.15 registers that the
// user is to write through the configuration port only while the unit is
// idle; the unit does not enforce this. The unit is a fully pipelined datapath
// that takes one request per clock unless a result is held back; its steps,
// in order: sine/cosine cordic, vector products, squaring of the clipped up
// component, square root (one root bit per stage), two parallel arctangent
// cordics, output register. A stall on the result side freezes the whole
// pipeline; a one-entry skid register on the request side still takes one
// request while a result waits, so o_stall is a registered signal.

module solar_altitude_azimuth_top import saa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_hour_angle,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_sun_east,
    output logic [15:0] o_sun_north,
    output logic [15:0] o_sun_up,
    output logic [15:0] o_altitude,
    output logic [15:0] o_azimuth,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic signed [MW-1:0]  Q30_ONE  = MW'(64'sd1 <<< 30);
    localparam logic        [SQW-1:0] Q60_ONE  = SQW'(64'd1 << 60);
    localparam logic signed [63:0]    ALT_MAX  = 64'sd16384;

    // configuration registers
    logic signed [15:0] r_decl_sine;
    logic signed [15:0] r_decl_cosine;
    logic signed [15:0] r_lat_sine;
    logic signed [15:0] r_lat_cosine;

    // request skid
    logic               r_skid_valid;
    logic signed [15:0] r_skid_h;

    // product stages
    logic               r_m1_v;
    logic signed [MW-1:0] r_m1_m;
    logic signed [MW-1:0] r_m1_e;
    logic signed [MW-1:0] r_m1_pcs;
    logic signed [MW-1:0] r_m1_pss;
    logic               r_m2_v;
    logic signed [MW-1:0] r_m2_e;
    logic signed [MW-1:0] r_m2_nn;
    logic signed [MW-1:0] r_m2_u;
    logic               r_m3_v;
    logic signed [31:0] r_m3_uc;
    logic signed [VW-1:0] r_m3_e;
    logic signed [VW-1:0] r_m3_nn;
    t_side              r_m3_side;

    // square root stages, entry 0 holds the radicand
    logic               r_sq_v    [0:SQ_STEPS];
    logic [SQW-1:0]     r_sq_n    [0:SQ_STEPS];
    logic [SQW-1:0]     r_sq_r    [0:SQ_STEPS];
    logic signed [31:0] r_sq_uc   [0:SQ_STEPS];
    logic signed [VW-1:0] r_sq_e  [0:SQ_STEPS];
    logic signed [VW-1:0] r_sq_nn [0:SQ_STEPS];
    t_side              r_sq_side [0:SQ_STEPS];

    // output register
    logic               r_out_valid;
    logic [15:0]        r_east;
    logic [15:0]        r_north;
    logic [15:0]        r_up;
    logic [15:0]        r_alt;
    logic [15:0]        r_az;

    logic               accept_in;
    logic               en;
    logic signed [15:0] h_sel;

    logic                 rot_v;
    logic signed [RW-1:0] rot_sin;
    logic signed [RW-1:0] rot_cos;

    logic                 vec_v;
    logic signed [ZW-1:0] vec_alt_z;
    logic signed [ZW-1:0] vec_az_z;
    t_side                vec_side;

    logic signed [63:0]   alt_w;
    logic signed [63:0]   az_w;
    t_side                n_side;
    logic signed [31:0]   n_uc;

    // configuration port: always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl_sine   <= 16'sd0;
            r_decl_cosine <= 16'sd32767;
            r_lat_sine    <= 16'sd0;
            r_lat_cosine  <= 16'sd32767;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DECL_SINE:   r_decl_sine   <= i_cfg_data;
                CFG_DECL_COSINE: r_decl_cosine <= i_cfg_data;
                CFG_LAT_SINE:    r_lat_sine    <= i_cfg_data;
                CFG_LAT_COSINE:  r_lat_cosine  <= i_cfg_data;
            endcase
        end
    end

    // pipeline moves unless a finished result is held back
    assign en        = !(r_out_valid && i_stall);
    assign accept_in = i_valid && !r_skid_valid;
    assign o_stall   = r_skid_valid;
    assign h_sel     = r_skid_valid ? r_skid_h : i_hour_angle;

    // skid fills only when a request arrives during a freeze
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (en) begin
            r_skid_valid <= 1'b0;
        end else if (accept_in) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && accept_in) begin
            r_skid_h <= i_hour_angle;
        end
    end

    // sine and cosine of the hour angle
    saa_rot_cordic u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_skid_valid || accept_in),
        .i_angle (ang_in(h_sel)),
        .o_valid (rot_v),
        .o_sin   (rot_sin),
        .o_cos   (rot_cos)
    );

    // first products: cos d cos h, -cos d sin h and the latitude/declination terms
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
        end else if (en) begin
            r_m1_v <= rot_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_m   <= MW'(rnd15(64'(r_decl_cosine) * 64'(rot_cos)));
            r_m1_e   <= MW'(-rnd15(64'(r_decl_cosine) * 64'(rot_sin)));
            r_m1_pcs <= MW'(64'(r_lat_cosine) * 64'(r_decl_sine));
            r_m1_pss <= MW'(64'(r_lat_sine) * 64'(r_decl_sine));
        end
    end

    // north and up components
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_v <= 1'b0;
        end else if (en) begin
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_e  <= r_m1_e;
            r_m2_nn <= r_m1_pcs - MW'(rnd15(64'(r_lat_sine) * 64'(r_m1_m)));
            r_m2_u  <= r_m1_pss + MW'(rnd15(64'(r_lat_cosine) * 64'(r_m1_m)));
        end
    end

    // clip up for the altitude, round the vector outputs, horizon and zenith test
    always_comb begin
        if (r_m2_u > Q30_ONE) begin
            n_uc = 32'(Q30_ONE);
        end else if (r_m2_u < -Q30_ONE) begin
            n_uc = 32'(-Q30_ONE);
        end else begin
            n_uc = r_m2_u[31:0];
        end
        n_side.east  = sat16(rnd15(64'(r_m2_e)));
        n_side.north = sat16(rnd15(64'(r_m2_nn)));
        n_side.up    = sat16(rnd15(64'(r_m2_u)));
        n_side.az_ok = (r_m2_u >= 0) && !((r_m2_e == 0) && (r_m2_nn == 0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3_v <= 1'b0;
        end else if (en) begin
            r_m3_v <= r_m2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m3_uc   <= n_uc;
            r_m3_e    <= VW'(r_m2_e);
            r_m3_nn   <= VW'(r_m2_nn);
            r_m3_side <= n_side;
        end
    end

    // radicand 1 - up^2 in q60
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (en) begin
            r_sq_v[0] <= r_m3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_n[0]    <= Q60_ONE - SQW'(64'(r_m3_uc) * 64'(r_m3_uc));
            r_sq_r[0]    <= '0;
            r_sq_uc[0]   <= r_m3_uc;
            r_sq_e[0]    <= r_m3_e;
            r_sq_nn[0]   <= r_m3_nn;
            r_sq_side[0] <= r_m3_side;
        end
    end

    // digit-by-digit integer square root, one root bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ_STEPS - 1 - k));
        logic [SQW-1:0] trial;

        assign trial = r_sq_r[k] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (en) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_sq_n[k] >= trial) begin
                    r_sq_n[k+1] <= r_sq_n[k] - trial;
                    r_sq_r[k+1] <= (r_sq_r[k] >> 1) + BIT;
                end else begin
                    r_sq_n[k+1] <= r_sq_n[k];
                    r_sq_r[k+1] <= r_sq_r[k] >> 1;
                end
                r_sq_uc[k+1]   <= r_sq_uc[k];
                r_sq_e[k+1]    <= r_sq_e[k];
                r_sq_nn[k+1]   <= r_sq_nn[k];
                r_sq_side[k+1] <= r_sq_side[k];
            end
        end
    end

    // altitude = atan2(up, sqrt(1-up^2)), azimuth = atan2(east, north)
    saa_vec_cordic u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_sq_v[SQ_STEPS]),
        .i_alt_y (VW'(r_sq_uc[SQ_STEPS])),
        .i_alt_x (VW'(r_sq_r[SQ_STEPS])),
        .i_az_y  (r_sq_e[SQ_STEPS]),
        .i_az_x  (r_sq_nn[SQ_STEPS]),
        .i_side  (r_sq_side[SQ_STEPS]),
        .o_valid (vec_v),
        .o_alt_z (vec_alt_z),
        .o_az_z  (vec_az_z),
        .o_side  (vec_side)
    );

    assign alt_w = ang_out(vec_alt_z);
    assign az_w  = ang_out(vec_az_z);

    // output register, altitude saturated to a quarter turn, azimuth wraps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= vec_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_east  <= vec_side.east;
            r_north <= vec_side.north;
            r_up    <= vec_side.up;
            if (alt_w > ALT_MAX) begin
                r_alt <= 16'(ALT_MAX);
            end else if (alt_w < -ALT_MAX) begin
                r_alt <= 16'(-ALT_MAX);
            end else begin
                r_alt <= alt_w[15:0];
            end
            r_az <= vec_side.az_ok ? az_w[15:0] : 16'd0;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_sun_east  = r_east;
    assign o_sun_north = r_north;
    assign o_sun_up    = r_up;
    assign o_altitude  = r_alt;
    assign o_azimuth   = r_az;

    // skid drains on the first cycle the pipeline moves
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && en |=> !r_skid_valid)
        else $error("skid entry not drained");

    // a request taken during a freeze lands in the skid
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !en |=> r_skid_valid)
        else $error("request lost during freeze");

    // azimuth only above the horizon
    a_az_horizon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_azimuth != 16'd0) |-> !o_sun_up[15])
        else $error("azimuth given below horizon");

    // altitude within a quarter turn
    a_alt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_altitude) <= 16'sd16384) &&
                    ($signed(o_altitude) >= -16'sd16384))
        else $error("altitude out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/saa_rot_cordic.sv =====
// pipelined rotation cordic giving sine and cosine of an angle
`default_nettype none

module saa_rot_cordic import saa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [ZW-1:0] i_angle,
    output logic                 o_valid,
    output logic signed [RW-1:0] o_sin,
    output logic signed [RW-1:0] o_cos
);

    localparam logic signed [ZW-1:0] HALF    = ZW'(1) << (ANGLE_BITS - 1);
    localparam logic signed [ZW-1:0] QUARTER = ZW'(1) << (ANGLE_BITS - 2);

    logic                 r_v   [0:CORDIC_STAGES];
    logic                 r_neg [0:CORDIC_STAGES];
    logic signed [RW-1:0] r_x   [0:CORDIC_STAGES];
    logic signed [RW-1:0] r_y   [0:CORDIC_STAGES];
    logic signed [ZW-1:0] r_z   [0:CORDIC_STAGES];
    logic                 r_ov;
    logic signed [RW-1:0] r_sin;
    logic signed [RW-1:0] r_cos;

    logic                 n_neg;
    logic signed [ZW-1:0] n_z;

    // fold into a half turn around zero
    always_comb begin
        n_neg = 1'b0;
        n_z   = i_angle;
        if (i_angle > QUARTER) begin
            n_z   = i_angle - HALF;
            n_neg = 1'b1;
        end else if (i_angle < -QUARTER) begin
            n_z   = i_angle + HALF;
            n_neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= n_neg;
            r_z[0]   <= n_z;
            r_x[0]   <= GAIN_INV;
            r_y[0]   <= '0;
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN = atan_ent(k);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k+1] <= r_neg[k];
                if (r_z[k] >= 0) begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - ATAN;
                end else begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + ATAN;
                end
            end
        end
    end

    // undo the half-turn fold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_neg[CORDIC_STAGES] ? -r_y[CORDIC_STAGES] : r_y[CORDIC_STAGES];
            r_cos <= r_neg[CORDIC_STAGES] ? -r_x[CORDIC_STAGES] : r_x[CORDIC_STAGES];
        end
    end

    assign o_valid = r_ov;
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

`default_nettype wire

// ===== hw/rtl/saa_vec_cordic.sv =====
// two-lane pipelined vectoring cordic for altitude and azimuth arctangents
`default_nettype none

module saa_vec_cordic import saa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [VW-1:0] i_alt_y,
    input  logic signed [VW-1:0] i_alt_x,
    input  logic signed [VW-1:0] i_az_y,
    input  logic signed [VW-1:0] i_az_x,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic signed [ZW-1:0] o_alt_z,
    output logic signed [ZW-1:0] o_az_z,
    output t_side                o_side
);

    localparam logic signed [ZW-1:0] QUARTER = ZW'(1) << (ANGLE_BITS - 2);

    logic                 r_v    [0:CORDIC_STAGES];
    t_side                r_side [0:CORDIC_STAGES];
    logic                 r_zero [0:1][0:CORDIC_STAGES];
    logic signed [VW-1:0] r_x    [0:1][0:CORDIC_STAGES];
    logic signed [VW-1:0] r_y    [0:1][0:CORDIC_STAGES];
    logic signed [ZW-1:0] r_z    [0:1][0:CORDIC_STAGES];

    logic signed [VW-1:0] in_y [0:1];
    logic signed [VW-1:0] in_x [0:1];

    assign in_y[0] = i_alt_y;
    assign in_x[0] = i_alt_x;
    assign in_y[1] = i_az_y;
    assign in_x[1] = i_az_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_ctl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1] <= r_side[k];
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        // pre-rotation of the left half plane by a quarter turn
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[l][0] <= (in_x[l] == 0) && (in_y[l] == 0);
                if (in_x[l] < 0) begin
                    if (in_y[l] >= 0) begin
                        r_x[l][0] <= in_y[l];
                        r_y[l][0] <= -in_x[l];
                        r_z[l][0] <= QUARTER;
                    end else begin
                        r_x[l][0] <= -in_y[l];
                        r_y[l][0] <= in_x[l];
                        r_z[l][0] <= -QUARTER;
                    end
                end else begin
                    r_x[l][0] <= in_x[l];
                    r_y[l][0] <= in_y[l];
                    r_z[l][0] <= '0;
                end
            end
        end

        for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
            localparam logic signed [ZW-1:0] ATAN = atan_ent(k);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_zero[l][k+1] <= r_zero[l][k];
                    if (r_y[l][k] >= 0) begin
                        r_x[l][k+1] <= r_x[l][k] + (r_y[l][k] >>> k);
                        r_y[l][k+1] <= r_y[l][k] - (r_x[l][k] >>> k);
                        r_z[l][k+1] <= r_z[l][k] + ATAN;
                    end else begin
                        r_x[l][k+1] <= r_x[l][k] - (r_y[l][k] >>> k);
                        r_y[l][k+1] <= r_y[l][k] + (r_x[l][k] >>> k);
                        r_z[l][k+1] <= r_z[l][k] - ATAN;
                    end
                end
            end
        end
    end

    // a zero vector has angle zero
    assign o_alt_z = r_zero[0][CORDIC_STAGES] ? '0 : r_z[0][CORDIC_STAGES];
    assign o_az_z  = r_zero[1][CORDIC_STAGES] ? '0 : r_z[1][CORDIC_STAGES];
    assign o_valid = r_v[CORDIC_STAGES];
    assign o_side  = r_side[CORDIC_STAGES];

endmodule

`default_nettype wire

// ===== tb/solar_altitude_azimuth_top_test.sv =====
// testbench for the solar altitude/azimuth unit: scoreboard with own sun geometry predictor
`default_nettype none

module solar_altitude_azimuth_top_test import saa_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // sun direction result
    typedef struct packed {
        logic [15:0] east;
        logic [15:0] north;
        logic [15:0] up;
        logic [15:0] alt;
        logic [15:0] az;
    } t_sun;

    class sun_scoreboard;
        t_sun pending[$];
        int   n_fail;
        int   n_checked;

        function void note_request(input t_sun exp_sun);
            pending.push_back(exp_sun);
        endfunction

        function void check_result(input t_sun got);
            t_sun want;
            n_checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result e=%h n=%h u=%h alt=%h az=%h", $time,
                         got.east, got.north, got.up, got.alt, got.az);
                n_fail++;
                return;
            end
            want = pending.pop_front();
            if (got.east !== want.east) begin
                $display("%0t: east exp %h got %h", $time, want.east, got.east);
                n_fail++;
            end
            if (got.north !== want.north) begin
                $display("%0t: north exp %h got %h", $time, want.north, got.north);
                n_fail++;
            end
            if (got.up !== want.up) begin
                $display("%0t: up exp %h got %h", $time, want.up, got.up);
                n_fail++;
            end
            if (got.alt !== want.alt) begin
                $display("%0t: altitude exp %h got %h", $time, want.alt, got.alt);
                n_fail++;
            end
            if (got.az !== want.az) begin
                $display("%0t: azimuth exp %h got %h", $time, want.az, got.az);
                n_fail++;
            end
        endfunction
    endclass

    localparam int LATENCY     = 71;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [15:0] req_hour = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [15:0] res_east, res_north, res_up, res_alt, res_az;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    t_cfg_idx    cfg_index = CFG_DECL_SINE;
    logic [15:0] cfg_data = '0;

    // predictor copy of the registers
    logic signed [15:0] sin_decl, cos_decl, sin_lat, cos_lat;

    sun_scoreboard sb;
    int  n_sent;
    int  n_cfg_phases;
    int  cycles;
    bit  stall_enable;

    always #1 clk = ~clk;

    solar_altitude_azimuth_top u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (req_valid),
        .o_stall      (req_stall),
        .i_hour_angle (req_hour),
        .o_valid      (res_valid),
        .i_stall      (res_stall),
        .o_sun_east   (res_east),
        .o_sun_north  (res_north),
        .o_sun_up     (res_up),
        .o_altitude   (res_alt),
        .o_azimuth    (res_az),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    // ---------------------------------------------------------------- predictor

    function automatic longint shr_round(input longint v, input int s);
        if (s <= 0) return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint atan_step(input int i);
        longint t;
        t = longint'(ATAN_TURN32[i % 32]);
        if (ANGLE_BITS < 32) t = (t + (64'sd1 <<< (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
        return t;
    endfunction

    function automatic longint angle_to_16(input longint z);
        if (ANGLE_BITS >= 16) return shr_round(z, ANGLE_BITS - 16);
        return z <<< (16 - ANGLE_BITS);
    endfunction

    function automatic longint clip16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint int_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // rotation cordic: sine and cosine of a cordic angle, q30
    function automatic void rotate_unit(input longint z, output longint sn,
                                        output longint cs);
        longint half, quarter, x, y, dx, dy;
        bit flip;
        half = 64'sd1 <<< (ANGLE_BITS - 1);
        quarter = 64'sd1 <<< (ANGLE_BITS - 2);
        flip = 0;
        x = 652032874;
        y = 0;
        if (z > quarter) begin
            z -= half;
            flip = 1;
        end else if (z < -quarter) begin
            z += half;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endfunction

    // vectoring cordic: atan2(y, x) in cordic units
    function automatic longint arctan2(input longint y, input longint x);
        longint z, t, dx, dy, quarter;
        quarter = 64'sd1 <<< (ANGLE_BITS - 2);
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = quarter;
            end else begin
                t = x; x = -y; y = t; z = -quarter;
            end
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_step(i);
            end else begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic t_sun sun_position(input logic signed [15:0] hour);
        longint sd, cd, sl, cl, z, sh, ch, m, e, nn, u, uc, c, alt, az;
        t_sun r;
        sd = longint'(sin_decl); cd = longint'(cos_decl);
        sl = longint'(sin_lat); cl = longint'(cos_lat);
        z = shr_round(longint'(hour) * 65536, 32 - ANGLE_BITS);
        rotate_unit(z, sh, ch);
        m = shr_round(cd * ch, 15);
        e = -shr_round(cd * sh, 15);
        nn = cl * sd - shr_round(sl * m, 15);
        u = sl * sd + shr_round(cl * m, 15);
        uc = u > (64'sd1 <<< 30) ? (64'sd1 <<< 30) :
             (u < -(64'sd1 <<< 30) ? -(64'sd1 <<< 30) : u);
        c = int_sqrt((64'd1 << 60) - longint'(uc * uc));
        alt = angle_to_16(arctan2(uc, c));
        if (alt > 16384) alt = 16384;
        if (alt < -16384) alt = -16384;
        az = (u >= 0) ? angle_to_16(arctan2(e, nn)) : 0;
        r.east = 16'(clip16(shr_round(e, 15)));
        r.north = 16'(clip16(shr_round(nn, 15)));
        r.up = 16'(clip16(shr_round(u, 15)));
        r.alt = alt[15:0];
        r.az = az[15:0];
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers

    // idle cycles between requests, with stretches of back to back traffic
    function automatic int draw_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 14);
    endfunction

    // valid stays high into the next request when no idle cycles are drawn
    task automatic send_request(input logic [15:0] hour);
        int gap;
        gap = draw_gap();
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_hour  <= hour;
        // accepted on an edge with valid high and stall low
        do @(posedge clk); while (req_stall);
        sb.note_request(sun_position(hour));
        n_sent++;
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_DECL_SINE:   sin_decl = value;
            CFG_DECL_COSINE: cos_decl = value;
            CFG_LAT_SINE:    sin_lat = value;
            CFG_LAT_COSINE:  cos_lat = value;
        endcase
    endtask

    // wait for every outstanding result, then let the pipe drain
    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic load_setting(input logic [15:0] sdv, cdv, slv, clv);
        drain();
        write_reg(CFG_DECL_SINE, sdv);
        write_reg(CFG_DECL_COSINE, cdv);
        write_reg(CFG_LAT_SINE, slv);
        write_reg(CFG_LAT_COSINE, clv);
        cfg_valid <= 1'b0;
        n_cfg_phases++;
    endtask

    // ---------------------------------------------------------------- result side

    // result stall drawn per result, disabled during some stretches
    initial begin
        int hold;
        @(posedge rst_n);
        forever begin
            hold = stall_enable ? $urandom_range(0, 14) : 0;
            if (hold != 0) begin
                res_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            res_stall <= 1'b0;
            do @(posedge clk); while (!res_valid);
        end
    end

    // sample accepted results at the edge
    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall) begin
            sb.check_result({res_east, res_north, res_up, res_alt, res_az});
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending.size());
            $display("** solar_altitude_azimuth_top: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin
        logic [15:0] edge_hours [12];
        logic [15:0] h;
        sb = new();
        cycles = 0;
        n_sent = 0;
        n_cfg_phases = 0;
        stall_enable = 1;
        // reset register values
        sin_decl = 16'sd0; cos_decl = 16'sd32767; sin_lat = 16'sd0; cos_lat = 16'sd32767;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, quarter turn boundaries for range reduction,
        // zenith point at reset setting (east and north both zero at noon)
        edge_hours = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'h4001, 16'hC000,
                       16'hBFFF, 16'h0001, 16'hFFFF, 16'h2000, 16'hE000, 16'h5555};
        foreach (edge_hours[i]) send_request(edge_hours[i]);

        // non-unit extremes: components saturate and the up value is clipped
        load_setting(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        foreach (edge_hours[i]) if (i < 6) send_request(edge_hours[i]);
        load_setting(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        foreach (edge_hours[i]) if (i < 6) send_request(edge_hours[i]);

        // random part: realistic settings mostly, with some arbitrary ones
        for (int phase = 0; phase < 9; phase++) begin
            if (phase % 3 == 2) begin
                load_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            end else begin
                // small declination with a near-unit cosine, moderate latitude
                load_setting(16'($signed($urandom_range(0, 26000)) - 13000),
                             16'($urandom_range(29000, 32767)),
                             16'($signed($urandom_range(0, 60000)) - 30000),
                             16'($urandom_range(1000, 32767)));
            end
            stall_enable = (phase != 4);
            for (int k = 0; k < 95; k++) begin
                h = 16'($urandom);
                send_request(h);
                // hold off once until the pipe is empty
                if (phase == 1 && k == 40) begin
                    req_valid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge clk);
                end
            end
        end
        stall_enable = 1;

        drain();
        $display("requests sent %0d, results checked %0d, register settings %0d",
                 n_sent, sb.n_checked, n_cfg_phases + 1);
        $display("covered angle extremes, saturating registers, random sun geometry");
        if (sb.n_fail == 0 && sb.pending.size() == 0) begin
            $display("** solar_altitude_azimuth_top: PASSED **");
        end else begin
            $display("** solar_altitude_azimuth_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
